// ===== sv/sil_pkg.sv =====
package sil_pkg;

  localparam int unsigned DefDepth = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CntW     = 5;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned OpW      = 3;
  localparam int unsigned StatW    = 2;
  localparam int unsigned CapReset = 16;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [CntW-1:0]         cnt_t;
  typedef logic [IdxW-1:0]         idx_t;

  typedef enum logic [OpW-1:0] {
    OpAppend     = 3'd0,
    OpInsert     = 3'd1,
    OpRemoveAt   = 3'd2,
    OpRemoveLast = 3'd3,
    OpRead       = 3'd4
  } op_e;

  typedef enum logic [StatW-1:0] {
    StDone = 2'd0,
    StFull = 2'd1,
    StBad  = 2'd2
  } status_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic app;
    logic ins;
    logic rem;
    cnt_t count;
    idx_t index;
  } cmd_t;

endpackage

// ===== sv/sil_cell.sv =====
module sil_cell #(
  parameter int unsigned Pos = 0
) (
  input  logic           clk_i,
  input  sil_pkg::cmd_t  cmd_i,
  input  sil_pkg::data_t value_i,
  input  sil_pkg::data_t left_i,
  input  sil_pkg::data_t right_i,
  input  logic           before_i,
  output logic           before_o,
  output sil_pkg::data_t entry_o
);

  sil_pkg::data_t entry_q, entry_d;
  logic           gt;
  logic           in_use;
  logic           at_count;
  logic           upto_count;
  logic           from_index;

  assign in_use     = 32'(cmd_i.count) > Pos;
  assign at_count   = 32'(cmd_i.count) == Pos;
  assign upto_count = 32'(cmd_i.count) >= Pos;
  assign from_index = 32'(cmd_i.index) <= Pos;
  assign gt         = in_use && (value_i > entry_q);
  assign before_o   = before_i & gt;
  assign entry_o    = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.app) begin
      if (at_count) entry_d = value_i;
    end else if (cmd_i.ins) begin
      if (before_i && !gt) begin
        entry_d = value_i;
      end else if (!before_i && upto_count) begin
        entry_d = left_i;
      end
    end else if (cmd_i.rem) begin
      if (from_index) entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== sv/sorted_insert_list.sv =====
// Bounded list of signed 32-bit entries held in a row of cells, one entry per
// cell. Each item appends, inserts in order, removes at an index, removes the
// last entry or reads at an index, and returns one result with the count, a
// status and the read data. Every cell compares the new value against its own
// entry and shifts from its neighbor in the same cycle, and the result is
// registered and shows the cycle after the item is accepted. A new item is
// taken in every cycle unless a result is held by out_stall_i. Capacity is the
// smaller of the capacity_limit register (byte address 0) and Depth; inserts
// beyond it report full and change nothing.
module sorted_insert_list #(
  parameter int unsigned Depth = sil_pkg::DefDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sil_pkg::OpW-1:0]       operation_i,
  input  logic signed [sil_pkg::DataW-1:0] value_i,
  input  logic [sil_pkg::IdxW-1:0]      index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sil_pkg::CntW-1:0]      count_o,
  output logic [sil_pkg::StatW-1:0]     status_o,
  output logic signed [sil_pkg::DataW-1:0] read_value_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned RdN = (Depth < 16) ? Depth : 16;

  sil_pkg::cnt_t    cap_q, count_q, count_d;
  logic             out_valid_q, out_valid_d;
  sil_pkg::cnt_t    res_count_q;
  sil_pkg::status_e res_status_q, status_d;
  sil_pkg::data_t   res_read_q, read_d;
  sil_pkg::cmd_t    cmd;
  sil_pkg::op_e     op;
  logic             accept;
  logic             cfg_wr;
  logic             full;
  logic             bad_idx;
  sil_pkg::data_t   rd_mux;
  sil_pkg::data_t   entry_w [Depth];
  logic             before_w [Depth+1];

  assign op      = sil_pkg::op_e'(operation_i);
  assign accept  = in_valid_i & ~in_stall_o;
  assign cfg_wr  = psel & penable & pwrite & pready & ~paddr[2];
  assign full    = (count_q >= cap_q) || (32'(count_q) >= Depth);
  assign bad_idx = sil_pkg::cnt_t'(index_i) >= count_q;

  assign in_stall_o   = out_valid_q & out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign count_o      = res_count_q;
  assign status_o     = res_status_q;
  assign read_value_o = res_read_q;
  assign pready       = 1'b1;
  assign prdata       = paddr[2] ? 32'd0 : 32'(cap_q);

  always_comb begin
    rd_mux = '0;
    for (int j = 0; j < RdN; j++) begin
      if (index_i == sil_pkg::idx_t'(j)) rd_mux = entry_w[j];
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.count = count_q;
    cmd.index = index_i;
    count_d   = count_q;
    status_d  = sil_pkg::StDone;
    read_d    = '0;
    case (op)
      sil_pkg::OpAppend, sil_pkg::OpInsert: begin
        if (full) begin
          status_d = sil_pkg::StFull;
        end else begin
          cmd.app = accept && (op == sil_pkg::OpAppend);
          cmd.ins = accept && (op == sil_pkg::OpInsert);
          count_d = count_q + 1'b1;
        end
      end
      sil_pkg::OpRemoveAt: begin
        if (bad_idx) begin
          status_d = sil_pkg::StBad;
        end else begin
          cmd.rem = accept;
          count_d = count_q - 1'b1;
        end
      end
      sil_pkg::OpRemoveLast: begin
        if (count_q == '0) begin
          status_d = sil_pkg::StBad;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      sil_pkg::OpRead: begin
        if (bad_idx) begin
          status_d = sil_pkg::StBad;
        end else begin
          read_d = rd_mux;
        end
      end
      default: begin
      end
    endcase
  end

  assign before_w[0] = 1'b1;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    sil_pkg::data_t left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign right_w = entry_w[g];
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end
    sil_cell #(
      .Pos(g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .value_i (value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .before_i(before_w[g]),
      .before_o(before_w[g+1]),
      .entry_o (entry_w[g])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= sil_pkg::cnt_t'(sil_pkg::CapReset);
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) cap_q <= pwdata[sil_pkg::CntW-1:0];
      if (accept) count_q <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_count_q  <= count_d;
      res_status_q <= status_d;
      res_read_q   <= read_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= Depth)
    else $error("count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item gave no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (op == sil_pkg::OpAppend || op == sil_pkg::OpInsert)
    |=> $stable(count_q))
    else $error("full insert changed count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(res_count_q) && $stable(res_read_q))
    else $error("held result changed");

endmodule
